@@ hdl/slum_pkg.sv @@
// Shared types and constants for the sorted-list union merge block.
package slum_pkg;

    localparam int DATA_W         = 32;
    localparam int ACTION_W       = 2;
    localparam int LIST_DEPTH_DEF = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_RUN    = 2'd2
    } t_action;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

@@ hdl/slum_if.sv @@
// Handshake interfaces for the input and result channels.
interface slum_in_if;
    logic                                valid;
    logic                                ready;
    logic [slum_pkg::ACTION_W-1:0]       action;
    logic signed [slum_pkg::DATA_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface slum_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [slum_pkg::DATA_W-1:0]  union_value;
    logic                                last;
    logic                                empty_res;
    logic                                overflow;

    modport source (output valid, output union_value, output last, output empty_res,
                    output overflow, input ready);
    modport sink   (input valid, input union_value, input last, input empty_res,
                    input overflow, output ready);
endinterface

@@ hdl/slum_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module slum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/slum_cmp.sv @@
// Shared signed compare unit: less-than and equality of two words.
module slum_cmp (
    input  logic signed [slum_pkg::DATA_W-1:0] i_x,
    input  logic signed [slum_pkg::DATA_W-1:0] i_y,
    output slum_pkg::t_cmp_res                 o_res
);
    import slum_pkg::*;

    always_comb begin
        o_res.lt = (i_x < i_y);
        o_res.eq = (i_x == i_y);
    end
endmodule

@@ hdl/sorted_list_union_merge.sv @@
// Top level: two list stores, a merge sequencer and one shared compare unit.
//
//  Channel | Dir | Handshake       | Payload
//  i_in    | in  | valid / ready   | action[1:0], value[31:0] signed
//  o_out   | out | valid / ready   | union_value[31:0] signed, last, empty_res, overflow
//
// A load is accepted while idle and the block stays ready. A run walks both stores
// with one compare unit, used up to three times a step: FETCH reads both stores,
// CHK_A skips a duplicate in the first list, CHK_B one in the second, ORDER emits
// the smaller head, and DONE closes the run. Ready is low for the whole run. A
// stalled result port holds the sequencer only when a new value is ready to move
// into the still occupied output register.
// Reset clears counts, drop flag and sequencer; store contents are not cleared.
module sorted_list_union_merge #(
    parameter int LIST_DEPTH = slum_pkg::LIST_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slum_in_if.sink       i_in,
    slum_out_if.source    o_out
);
    import slum_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHK_A,
        ST_CHK_B,
        ST_ORDER,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic          r_drop, n_drop;
    logic          r_pend_v, n_pend_v;
    logic          r_out_v, n_out_v;
    logic signed [DATA_W-1:0] r_pend, n_pend;
    logic signed [DATA_W-1:0] r_prev_a, n_prev_a, r_prev_b, n_prev_b;
    logic signed [DATA_W-1:0] r_out_val, n_out_val;
    logic          r_out_last, n_out_last, r_out_empty, n_out_empty, r_out_ovf, n_out_ovf;

    logic                     we_a, we_b;
    logic signed [DATA_W-1:0] rd_a, rd_b;
    logic signed [DATA_W-1:0] cmp_x, cmp_y;
    t_cmp_res                 cmp;
    logic                     avail_a, avail_b, out_free, accept;

    slum_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (rd_a)
    );

    slum_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (rd_b)
    );

    // The sequencer steers both operands of the one compare unit.
    always_comb begin
        cmp_x = rd_a;
        cmp_y = rd_b;
        unique case (r_state)
            ST_CHK_A: cmp_y = r_prev_a;
            ST_CHK_B: begin
                cmp_x = rd_b;
                cmp_y = r_prev_b;
            end
            default: ;
        endcase
    end

    slum_cmp u_cmp (
        .i_x   (cmp_x),
        .i_y   (cmp_y),
        .o_res (cmp)
    );

    assign avail_a  = (r_i < r_cnt_a);
    assign avail_b  = (r_j < r_cnt_b);
    assign out_free = !r_out_v || o_out.ready;
    assign accept   = i_in.valid && (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_drop      = r_drop;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        n_prev_a    = r_prev_a;
        n_prev_b    = r_prev_b;
        n_out_v     = r_out_v && !o_out.ready;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_ovf   = r_out_ovf;
        we_a        = 1'b0;
        we_b        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.action)
                        ACT_LOAD_A: begin
                            if (r_cnt_a < CW'(LIST_DEPTH)) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        ACT_LOAD_B: begin
                            if (r_cnt_b < CW'(LIST_DEPTH)) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        ACT_RUN: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_state = ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: n_state = ST_CHK_A;
            ST_CHK_A: begin
                // An element equal to its predecessor in the same list is skipped.
                if (avail_a && (r_i != '0) && cmp.eq) begin
                    n_i     = r_i + CW'(1);
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_CHK_B;
                end
            end
            ST_CHK_B: begin
                if (avail_b && (r_j != '0) && cmp.eq) begin
                    n_j     = r_j + CW'(1);
                    n_state = ST_FETCH;
                end else if (!avail_a && !avail_b) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ORDER;
                end
            end
            ST_ORDER: begin
                // The newest value waits in the pending slot until the next one
                // shows whether it is the last of the run.
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_v     = 1'b1;
                        n_out_val   = r_pend;
                        n_out_last  = 1'b0;
                        n_out_empty = 1'b0;
                        n_out_ovf   = r_drop;
                    end
                    n_pend_v = 1'b1;
                    n_state  = ST_FETCH;
                    if (avail_a && (!avail_b || cmp.lt || cmp.eq)) begin
                        n_pend   = rd_a;
                        n_prev_a = rd_a;
                        n_i      = r_i + CW'(1);
                        if (avail_b && cmp.eq) begin
                            n_prev_b = rd_b;
                            n_j      = r_j + CW'(1);
                        end
                    end else begin
                        n_pend   = rd_b;
                        n_prev_b = rd_b;
                        n_j      = r_j + CW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_v     = 1'b1;
                    n_out_val   = r_pend_v ? r_pend : '0;
                    n_out_last  = 1'b1;
                    n_out_empty = !r_pend_v;
                    n_out_ovf   = r_drop;
                    n_pend_v    = 1'b0;
                    n_cnt_a     = '0;
                    n_cnt_b     = '0;
                    n_drop      = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_drop   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_i      <= n_i;
            r_j      <= n_j;
            r_drop   <= n_drop;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_pend      <= n_pend;
        r_prev_a    <= n_prev_a;
        r_prev_b    <= n_prev_b;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_v;
    assign o_out.union_value = r_out_val;
    assign o_out.last        = r_out_last;
    assign o_out.empty_res   = r_out_empty;
    assign o_out.overflow    = r_out_ovf;
endmodule

@@ hdl/slum_checker.sv @@
// Port-level checks for the sorted-list union merge block, bound to the top level.
module slum_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic [slum_pkg::ACTION_W-1:0]       i_in_action,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [slum_pkg::DATA_W-1:0]  i_out_union_value,
    input logic                                i_out_last,
    input logic                                i_out_empty_res
);
    import slum_pkg::*;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_union_value) && $stable(i_out_last)))
        else $error("stalled result changed");

    // The empty marker only ever appears on the closing result of a run.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_empty_res) |-> i_out_last)
        else $error("empty result not marked last");

    // A run occupies the block, so input is refused on the next cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_action == ACT_RUN)) |=> !i_in_ready)
        else $error("input accepted right after a run started");
endmodule

bind sorted_list_union_merge slum_checker u_slum_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_action       (i_in.action),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_union_value (o_out.union_value),
    .i_out_last        (o_out.last),
    .i_out_empty_res   (o_out.empty_res)
);

@@ tb/sv/tb_sorted_list_union_merge.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sorted-list union merge block.
module tb_sorted_list_union_merge;
    import slum_pkg::*;

    localparam int               DEPTH       = LIST_DEPTH_DEF;
    localparam int               CYCLE_LIMIT = 200000;
    localparam int               RANDOM_ITEMS = 120;
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [ACTION_W-1:0]       action;
        logic signed [DATA_W-1:0]  value;
        bit                        wait_idle;
    } t_cmd;

    typedef struct {
        logic signed [DATA_W-1:0]  value;
        logic                      last;
        logic                      is_empty;
        logic                      overflow;
    } t_union_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    slum_in_if  in_if ();
    slum_out_if out_if ();

    sorted_list_union_merge u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_cmd                       cmd_q[$];
    t_union_result              union_q[$];
    logic signed [DATA_W-1:0]   first_list[$];
    logic signed [DATA_W-1:0]   second_list[$];
    bit                         load_dropped;
    bit                         calm;
    int                         send_gap;
    int                         recv_gap;
    int                         failures;
    int                         cycle_count;
    int                         items_sent;
    int                         runs_sent;
    int                         results_checked;
    int                         drops_seen;
    int                         ignored_sent;

    task automatic queue_cmd(input logic [ACTION_W-1:0] action,
                             input logic signed [DATA_W-1:0] value, input bit wait_idle);
        t_cmd c;
        c.action    = action;
        c.value     = value;
        c.wait_idle = wait_idle;
        cmd_q = {cmd_q, c};
    endtask

    // Two-pointer union with per-list duplicate skipping; appends to union_q.
    task automatic predict_union();
        t_union_result run_q[$];
        t_union_result r;
        int i;
        int j;
        int n;
        int m;
        i = 0;
        j = 0;
        n = first_list.size();
        m = second_list.size();
        r.last     = 1'b0;
        r.is_empty = 1'b0;
        r.overflow = load_dropped;
        while (i < n && j < m) begin
            if (i > 0 && first_list[i] == first_list[i-1]) begin
                i++;
            end else if (j > 0 && second_list[j] == second_list[j-1]) begin
                j++;
            end else if (first_list[i] < second_list[j]) begin
                r.value = first_list[i];
                run_q = {run_q, r};
                i++;
            end else if (second_list[j] < first_list[i]) begin
                r.value = second_list[j];
                run_q = {run_q, r};
                j++;
            end else begin
                r.value = first_list[i];
                run_q = {run_q, r};
                i++;
                j++;
            end
        end
        for (; i < n; i++) begin
            if (!(i > 0 && first_list[i] == first_list[i-1])) begin
                r.value = first_list[i];
                run_q = {run_q, r};
            end
        end
        for (; j < m; j++) begin
            if (!(j > 0 && second_list[j] == second_list[j-1])) begin
                r.value = second_list[j];
                run_q = {run_q, r};
            end
        end
        if (run_q.size() == 0) begin
            r.value    = '0;
            r.is_empty = 1'b1;
            run_q = {run_q, r};
        end
        run_q[run_q.size()-1].last = 1'b1;
        union_q = {union_q, run_q};
        first_list.delete();
        second_list.delete();
        load_dropped = 1'b0;
    endtask

    task automatic apply_cmd(input logic [ACTION_W-1:0] action,
                             input logic signed [DATA_W-1:0] value);
        items_sent++;
        case (action)
            ACT_LOAD_A: begin
                if (first_list.size() < DEPTH) begin
                    first_list = {first_list, value};
                end else begin
                    load_dropped = 1'b1;
                    drops_seen++;
                end
            end
            ACT_LOAD_B: begin
                if (second_list.size() < DEPTH) begin
                    second_list = {second_list, value};
                end else begin
                    load_dropped = 1'b1;
                    drops_seen++;
                end
            end
            ACT_RUN: begin
                runs_sent++;
                predict_union();
            end
            default: ignored_sent++;
        endcase
    endtask

    // Mode 0: full range, mode 1: a narrow band so the lists share values,
    // mode 2: values at and next to the signed extremes.
    task automatic make_list(input int count, input int mode, input bit in_order,
                             ref int vals[$]);
        int v;
        vals.delete();
        repeat (count) begin
            case (mode)
                0: v = int'($urandom);
                1: v = int'($urandom_range(0, 8)) - 4;
                default: begin
                    case ($urandom_range(0, 6))
                        0: v = VAL_MIN;
                        1: v = VAL_MIN + 1;
                        2: v = -1;
                        3: v = 0;
                        4: v = 1;
                        5: v = VAL_MAX - 1;
                        default: v = VAL_MAX;
                    endcase
                end
            endcase
            vals = {vals, v};
        end
        if (in_order) vals.sort();
    endtask

    always @(posedge i_clk) begin : drive
        t_cmd c;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) apply_cmd(in_if.action, in_if.value);
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (cmd_q.size() == 0 ||
                             (cmd_q[0].wait_idle && union_q.size() != 0)) begin
                    in_if.valid <= 1'b0;
                end else begin
                    c = cmd_q.pop_front();
                    in_if.valid  <= 1'b1;
                    in_if.action <= c.action;
                    in_if.value  <= c.value;
                    if (cmd_q.size() < 25) calm = 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 12);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_union_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (union_q.size() == 0) begin
                    $error("result with nothing expected: union_value %0d last %0b",
                           out_if.union_value, out_if.last);
                    failures++;
                end else begin
                    want = union_q.pop_front();
                    results_checked++;
                    if (out_if.empty_res !== want.is_empty) begin
                        $error("empty_res: expected %0b, actual %0b",
                               want.is_empty, out_if.empty_res);
                        failures++;
                    end
                    if (!want.is_empty && out_if.union_value !== want.value) begin
                        $error("union_value: expected %0d, actual %0d",
                               want.value, out_if.union_value);
                        failures++;
                    end
                    if (out_if.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, out_if.last);
                        failures++;
                    end
                    if (out_if.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, out_if.overflow);
                        failures++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge i_clk) cycle_count++;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int  first_vals[$];
        int  second_vals[$];
        int  planned;
        int  seq;
        int  na;
        int  nb;
        int  mode;
        bit  in_order;
        bit  hold;
        bit  first_cmd;
        bit  to_first;

        in_if.valid  = 1'b0;
        in_if.action = ACT_LOAD_A;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;

        // Directed part: empty union, extremes with duplicates and equal heads,
        // an ignored action, one list only, and unsorted input.
        queue_cmd(ACT_RUN, 32'sh1234_5678, 1'b0);
        queue_cmd(ACT_LOAD_A, VAL_MIN, 1'b1);
        queue_cmd(ACT_LOAD_A, VAL_MIN, 1'b0);
        queue_cmd(ACT_LOAD_A, -1, 1'b0);
        queue_cmd(ACT_LOAD_A, 0, 1'b0);
        queue_cmd(ACT_LOAD_A, VAL_MAX, 1'b0);
        queue_cmd(ACT_LOAD_B, VAL_MIN, 1'b0);
        queue_cmd(ACT_LOAD_B, 0, 1'b0);
        queue_cmd(ACT_LOAD_B, 5, 1'b0);
        queue_cmd(ACT_LOAD_B, VAL_MAX, 1'b0);
        queue_cmd(ACT_LOAD_B, VAL_MAX, 1'b0);
        queue_cmd(ACT_IGNORED, 32'sh5555_5555, 1'b0);
        queue_cmd(ACT_RUN, 0, 1'b0);
        queue_cmd(ACT_LOAD_B, 7, 1'b1);
        queue_cmd(ACT_LOAD_B, 7, 1'b0);
        queue_cmd(ACT_RUN, -1, 1'b0);
        queue_cmd(ACT_LOAD_A, 3, 1'b1);
        queue_cmd(ACT_LOAD_A, 1, 1'b0);
        queue_cmd(ACT_LOAD_A, 1, 1'b0);
        queue_cmd(ACT_LOAD_B, 2, 1'b0);
        queue_cmd(ACT_RUN, VAL_MAX, 1'b0);
        queue_cmd(ACT_LOAD_A, 9, 1'b1);
        queue_cmd(ACT_RUN, VAL_MIN, 1'b0);

        // Random part: mostly sorted list pairs followed by a run. The first two
        // sequences overfill one list each; a few later ones fill a list too.
        planned = 0;
        seq     = 0;
        while (planned < RANDOM_ITEMS) begin
            na = $urandom_range(0, 8);
            nb = $urandom_range(0, 8);
            if (seq == 0) na = DEPTH + 2;
            else if (seq == 1) nb = DEPTH + 1;
            else if ($urandom_range(0, 11) == 0) na = DEPTH + $urandom_range(0, 3);
            else if ($urandom_range(0, 11) == 0) nb = DEPTH + $urandom_range(0, 3);
            mode     = $urandom_range(0, 2);
            in_order = ($urandom_range(0, 5) != 0);
            hold     = ($urandom_range(0, 3) == 0);
            make_list(na, mode, in_order, first_vals);
            make_list(nb, mode, in_order, second_vals);
            first_cmd = 1'b1;
            while (first_vals.size() != 0 || second_vals.size() != 0) begin
                if (first_vals.size() == 0) to_first = 1'b0;
                else if (second_vals.size() == 0) to_first = 1'b1;
                else to_first = $urandom_range(0, 1);
                if (to_first) queue_cmd(ACT_LOAD_A, first_vals.pop_front(), first_cmd && hold);
                else queue_cmd(ACT_LOAD_B, second_vals.pop_front(), first_cmd && hold);
                first_cmd = 1'b0;
                planned++;
                if ($urandom_range(0, 19) == 0) queue_cmd(ACT_IGNORED, $urandom, 1'b0);
            end
            // Now and then the run is left out so the next lists pile on.
            if (seq < 2 || $urandom_range(0, 9) != 0) begin
                queue_cmd(ACT_RUN, $urandom, first_cmd && hold);
                planned++;
            end
            seq++;
        end
        queue_cmd(ACT_RUN, $urandom, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (union_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d items accepted, %0d merge runs, %0d results checked",
                 items_sent, runs_sent, results_checked);
        $display("%0d loads dropped on full lists, %0d ignored actions",
                 drops_seen, ignored_sent);
        if (failures == 0 && union_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
